/* rtl/lrbc_pkg.sv */
`default_nettype none

package lrbc_pkg;

    // request kinds carried in req_type
    typedef enum logic [1:0] {
        REQ_CONNECT    = 2'd0,
        REQ_DISCONNECT = 2'd1,
        REQ_TICK       = 2'd2,
        REQ_UNUSED     = 2'd3
    } req_type_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RESCAN_DROPS  = 2'd0,
        CFG_BACKOFF_FLOOR = 2'd1,
        CFG_BACKOFF_CAP   = 2'd2,
        CFG_NONE          = 2'd3
    } cfg_index_t;

    localparam logic [7:0]  RESCAN_DROPS_RST  = 8'd5;
    localparam logic [31:0] BACKOFF_FLOOR_RST = 32'd3000;
    localparam logic [31:0] BACKOFF_CAP_RST   = 32'd30000;
    localparam logic [7:0]  DROP_COUNT_MAX    = 8'd255;

    // disconnect reason codes
    localparam logic [7:0] REASON_DROP_A  = 8'd2;
    localparam logic [7:0] REASON_DROP_B  = 8'd4;
    localparam logic [7:0] REASON_STALE_A = 8'd200;
    localparam logic [7:0] REASON_STALE_B = 8'd201;
    localparam logic [7:0] REASON_STALE_C = 8'd203;
    localparam logic [7:0] REASON_BOTH    = 8'd205;

    typedef struct packed {
        logic [7:0]  drop_counter;
        logic        rescan_pending;
        logic        retry_armed;
        logic [31:0] retry_deadline;
        logic [31:0] backoff_now;
    } sched_state_t;

    typedef struct packed {
        logic [7:0]  rescan_drops;
        logic [31:0] backoff_floor_ms;
        logic [31:0] backoff_cap_ms;
    } sched_cfg_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [7:0]  reason_code;
        logic [31:0] now_ms;
        logic        link_up;
    } sched_req_t;

    typedef struct packed {
        logic        clear_hint;
        logic        rescan_request;
        logic        reconnect_request;
        logic [31:0] current_backoff_ms;
        logic [7:0]  drop_count;
    } sched_result_t;

endpackage

`default_nettype wire

/* rtl/lrbc_core.sv */
`default_nettype none

module lrbc_core
    import lrbc_pkg::*;
(
    input  wire sched_state_t  state_cur,
    input  wire sched_cfg_t    cfg,
    input  wire sched_req_t    req,
    output sched_state_t       state_nxt,
    output sched_result_t      result
);

    logic        stale_hint;
    logic        counted_drop;
    logic [7:0]  drop_inc;
    logic [32:0] doubled;
    logic        deadline_due;

    always_comb begin
        stale_hint   = (req.reason_code == REASON_STALE_A) ||
                       (req.reason_code == REASON_STALE_B) ||
                       (req.reason_code == REASON_STALE_C) ||
                       (req.reason_code == REASON_BOTH);
        counted_drop = (req.reason_code == REASON_DROP_A) ||
                       (req.reason_code == REASON_DROP_B) ||
                       (req.reason_code == REASON_BOTH);
        drop_inc     = (state_cur.drop_counter == DROP_COUNT_MAX) ?
                       state_cur.drop_counter : state_cur.drop_counter + 8'd1;
        doubled      = {state_cur.backoff_now, 1'b0};
        deadline_due = state_cur.retry_armed && !req.link_up &&
                       (req.now_ms >= state_cur.retry_deadline);

        state_nxt                 = state_cur;
        result.clear_hint         = 1'b0;
        result.rescan_request     = 1'b0;
        result.reconnect_request  = 1'b0;

        case (req.req_type)
            REQ_CONNECT: begin
                state_nxt.drop_counter = '0;
                state_nxt.retry_armed  = 1'b0;
                state_nxt.backoff_now  = cfg.backoff_floor_ms;
            end
            REQ_DISCONNECT: begin
                result.clear_hint = stale_hint;
                if (counted_drop) begin
                    state_nxt.drop_counter = drop_inc;
                    if (drop_inc >= cfg.rescan_drops) begin
                        state_nxt.rescan_pending = 1'b1;
                    end
                end
                if (!state_cur.retry_armed) begin
                    state_nxt.retry_deadline = req.now_ms + state_cur.backoff_now;
                    state_nxt.retry_armed    = 1'b1;
                    state_nxt.backoff_now    = (doubled > {1'b0, cfg.backoff_cap_ms}) ?
                                               cfg.backoff_cap_ms : doubled[31:0];
                end
            end
            REQ_TICK: begin
                if (state_cur.rescan_pending) begin
                    state_nxt.rescan_pending = 1'b0;
                    state_nxt.drop_counter   = '0;
                    state_nxt.retry_armed    = 1'b0;
                    result.rescan_request    = 1'b1;
                    result.clear_hint        = 1'b1;
                end else if (deadline_due) begin
                    state_nxt.retry_armed    = 1'b0;
                    result.reconnect_request = 1'b1;
                end
            end
            default: begin
                state_nxt = state_cur;
            end
        endcase

        result.current_backoff_ms = state_nxt.backoff_now;
        result.drop_count         = state_nxt.drop_counter;
    end

endmodule

`default_nettype wire

/* rtl/link_reconnect_backoff_controller.sv */
`default_nettype none

// Reconnect scheduler with exponential backoff. Each request is a connect
// success, a disconnect (with reason code) or a periodic tick (with link
// status), and each gives exactly one result carrying the request flags,
// the backoff and the drop count after that request. A request is latched
// in an input register, processed against the scheduler state once the
// output register is free or draining, and its result lands in the output
// register; a new request is taken every cycle while the result side keeps
// up, so sustained throughput is one request per clock.
// The config port writes rescan_drops (index 0), backoff_floor_ms (1) and
// backoff_cap_ms (2); other indexes are ignored. Writes are meant for idle
// time only. A new floor is used at the next connect success.

module link_reconnect_backoff_controller
    import lrbc_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,

    // configuration write port
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_wdata,

    // request channel
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_req_type,
    input  wire  [7:0]  s_reason_code,
    input  wire  [31:0] s_now_ms,
    input  wire         s_link_up,

    // result channel
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_clear_hint,
    output logic        m_rescan_request,
    output logic        m_reconnect_request,
    output logic [31:0] m_current_backoff_ms,
    output logic [7:0]  m_drop_count
);

    // config registers
    sched_cfg_t    cfg_reg;

    // scheduler state
    sched_state_t  state_reg;
    sched_state_t  state_next;

    // input register
    logic          in_valid_reg;
    sched_req_t    in_req_reg;

    // output register
    logic          out_valid_reg;
    sched_result_t out_res_reg;
    sched_result_t res_next;

    logic          proc_fire;
    logic          in_accept;

    // process the held request when the output slot is free or draining
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign in_accept = s_valid && s_ready;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rescan_drops     <= RESCAN_DROPS_RST;
            cfg_reg.backoff_floor_ms <= BACKOFF_FLOOR_RST;
            cfg_reg.backoff_cap_ms   <= BACKOFF_CAP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_RESCAN_DROPS:  cfg_reg.rescan_drops     <= cfg_wdata[7:0];
                CFG_BACKOFF_FLOOR: cfg_reg.backoff_floor_ms <= cfg_wdata;
                CFG_BACKOFF_CAP:   cfg_reg.backoff_cap_ms   <= cfg_wdata;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // input register: valid is control, payload loads on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_req_reg.req_type    <= req_type_t'(s_req_type);
            in_req_reg.reason_code <= s_reason_code;
            in_req_reg.now_ms      <= s_now_ms;
            in_req_reg.link_up     <= s_link_up;
        end
    end

    // next-state and result logic for one request
    lrbc_core u_core (
        .state_cur (state_reg),
        .cfg       (cfg_reg),
        .req       (in_req_reg),
        .state_nxt (state_next),
        .result    (res_next)
    );

    // scheduler state; backoff starts at the floor reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.drop_counter   <= '0;
            state_reg.rescan_pending <= 1'b0;
            state_reg.retry_armed    <= 1'b0;
            state_reg.retry_deadline <= '0;
            state_reg.backoff_now    <= BACKOFF_FLOOR_RST;
        end else if (proc_fire) begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_clear_hint         = out_res_reg.clear_hint;
    assign m_rescan_request     = out_res_reg.rescan_request;
    assign m_reconnect_request  = out_res_reg.reconnect_request;
    assign m_current_backoff_ms = out_res_reg.current_backoff_ms;
    assign m_drop_count         = out_res_reg.drop_count;

`ifndef SYNTHESIS
    // an empty output slot never blocks the request side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("request side stalled with empty output register");

    // rescan and reconnect are exclusive in one result
    a_req_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_res_reg.rescan_request && out_res_reg.reconnect_request))
        else $error("rescan and reconnect in the same result");

    // a rescan result reports a cleared drop count
    a_rescan_clears_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.rescan_request |-> out_res_reg.drop_count == 8'd0)
        else $error("rescan result with nonzero drop count");

    // a reconnect result never asks for a hint clear
    a_reconnect_no_hint: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.reconnect_request |-> !out_res_reg.clear_hint)
        else $error("reconnect result with hint clear");

    // a processed disconnect always leaves a retry armed
    a_disconnect_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_req_reg.req_type == REQ_DISCONNECT |=> state_reg.retry_armed)
        else $error("disconnect left no retry armed");
`endif

endmodule

`default_nettype wire

/* test/link_reconnect_backoff_controller_tb.sv */
`default_nettype none

module link_reconnect_backoff_controller_tb;
    import lrbc_pkg::*;

    // generous bound on the whole run, in clock cycles
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_NONE;
    logic [31:0] cfg_wdata = '0;

    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type    = REQ_CONNECT;
    logic [7:0]  s_reason_code = '0;
    logic [31:0] s_now_ms      = '0;
    logic        s_link_up     = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_clear_hint;
    logic        m_rescan_request;
    logic        m_reconnect_request;
    logic [31:0] m_current_backoff_ms;
    logic [7:0]  m_drop_count;

    link_reconnect_backoff_controller u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_req_type           (s_req_type),
        .s_reason_code        (s_reason_code),
        .s_now_ms             (s_now_ms),
        .s_link_up            (s_link_up),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_clear_hint         (m_clear_hint),
        .m_rescan_request     (m_rescan_request),
        .m_reconnect_request  (m_reconnect_request),
        .m_current_backoff_ms (m_current_backoff_ms),
        .m_drop_count         (m_drop_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the scheduler: register copy and state copy
    sched_cfg_t    cfg_shadow;
    sched_state_t  sched;
    sched_result_t predicted_outcomes[$];

    // idling knobs for the stimulus and the result side
    int unsigned tx_gap_max    = 0;
    int unsigned rx_stall_max  = 0;
    int          rx_hold_cycles = 0;
    int          ready_wait     = 0;

    // running time base for the random requests
    logic [31:0] sim_ms = '0;

    int error_count      = 0;
    int requests_sent    = 0;
    int results_checked  = 0;
    int reconnects_seen  = 0;
    int rescans_seen     = 0;
    int settings_loaded  = 0;
    int cycle_count      = 0;

    logic [7:0] notable_reasons [6] = '{REASON_DROP_A, REASON_DROP_B, REASON_STALE_A,
                                        REASON_STALE_B, REASON_STALE_C, REASON_BOTH};

    // one step of the scheduler: updates the shadow state and returns the result
    function automatic sched_result_t advance_schedule(input logic [1:0] kind,
                                                      input logic [7:0] reason,
                                                      input logic [31:0] now,
                                                      input logic up);
        sched_result_t r;
        logic [32:0]   doubled;
        r = '0;
        case (kind)
            REQ_CONNECT: begin
                sched.drop_counter = '0;
                sched.retry_armed  = 1'b0;
                sched.backoff_now  = cfg_shadow.backoff_floor_ms;
            end
            REQ_DISCONNECT: begin
                // stale access point hint
                if (reason == REASON_STALE_A || reason == REASON_STALE_B ||
                    reason == REASON_STALE_C || reason == REASON_BOTH) begin
                    r.clear_hint = 1'b1;
                end
                // counted drop, saturating, may flag a rescan
                if (reason == REASON_DROP_A || reason == REASON_DROP_B ||
                    reason == REASON_BOTH) begin
                    if (sched.drop_counter != DROP_COUNT_MAX) begin
                        sched.drop_counter = sched.drop_counter + 8'd1;
                    end
                    if (sched.drop_counter >= cfg_shadow.rescan_drops) begin
                        sched.rescan_pending = 1'b1;
                    end
                end
                // arm a single retry, then double the backoff up to the cap
                if (!sched.retry_armed) begin
                    sched.retry_deadline = now + sched.backoff_now;
                    sched.retry_armed    = 1'b1;
                    doubled = {sched.backoff_now, 1'b0};
                    if (doubled > {1'b0, cfg_shadow.backoff_cap_ms}) begin
                        sched.backoff_now = cfg_shadow.backoff_cap_ms;
                    end else begin
                        sched.backoff_now = doubled[31:0];
                    end
                end
            end
            REQ_TICK: begin
                if (sched.rescan_pending) begin
                    sched.rescan_pending = 1'b0;
                    sched.drop_counter   = '0;
                    sched.retry_armed    = 1'b0;
                    r.rescan_request     = 1'b1;
                    r.clear_hint         = 1'b1;
                end else if (sched.retry_armed && !up && now >= sched.retry_deadline) begin
                    sched.retry_armed   = 1'b0;
                    r.reconnect_request = 1'b1;
                end
            end
            default: begin
                // unused request kind leaves the state alone
            end
        endcase
        r.current_backoff_ms = sched.backoff_now;
        r.drop_count         = sched.drop_counter;
        return r;
    endfunction

    // result side: random stalls per result, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_wait = 0;
        end else if (rx_hold_cycles > 0) begin
            rx_hold_cycles = rx_hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            ready_wait = $urandom_range(0, rx_stall_max);
            m_ready <= (ready_wait == 0);
        end else if (ready_wait > 0) begin
            ready_wait = ready_wait - 1;
            m_ready <= (ready_wait == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge aclk) begin : result_compare
        sched_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_outcomes.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                want = predicted_outcomes.pop_front();
                results_checked++;
                if (m_clear_hint !== want.clear_hint) begin
                    $error("clear_hint: expected %0d, got %0d", want.clear_hint, m_clear_hint);
                    error_count++;
                end
                if (m_rescan_request !== want.rescan_request) begin
                    $error("rescan_request: expected %0d, got %0d",
                           want.rescan_request, m_rescan_request);
                    error_count++;
                end
                if (m_reconnect_request !== want.reconnect_request) begin
                    $error("reconnect_request: expected %0d, got %0d",
                           want.reconnect_request, m_reconnect_request);
                    error_count++;
                end
                if (m_current_backoff_ms !== want.current_backoff_ms) begin
                    $error("current_backoff_ms: expected %0d, got %0d",
                           want.current_backoff_ms, m_current_backoff_ms);
                    error_count++;
                end
                if (m_drop_count !== want.drop_count) begin
                    $error("drop_count: expected %0d, got %0d", want.drop_count, m_drop_count);
                    error_count++;
                end
                if (want.reconnect_request) reconnects_seen++;
                if (want.rescan_request) rescans_seen++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, predicted_outcomes.size());
        $display("link_reconnect_backoff_controller: mismatch");
        $finish;
    end

    // one request: optional idle gap, then hold valid until taken
    task automatic send_request(input logic [1:0] kind, input logic [7:0] reason,
                                input logic [31:0] now, input logic up);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= kind;
        s_reason_code <= reason;
        s_now_ms      <= now;
        s_link_up     <= up;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted_outcomes.push_back(advance_schedule(kind, reason, now, up));
        requests_sent++;
    endtask

    // stop offering and let every predicted result come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (predicted_outcomes.size() != 0) @(posedge aclk);
    endtask

    // write all three registers plus one ignored index, block idle
    task automatic load_settings(input logic [7:0] thr, input logic [31:0] floor_ms,
                                 input logic [31:0] cap_ms);
        logic [31:0] noise;
        wait_for_results();
        noise = $urandom;
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_RESCAN_DROPS;
        cfg_wdata <= {noise[31:8], thr};
        @(posedge aclk);
        cfg_index <= CFG_BACKOFF_FLOOR;
        cfg_wdata <= floor_ms;
        @(posedge aclk);
        cfg_index <= CFG_BACKOFF_CAP;
        cfg_wdata <= cap_ms;
        @(posedge aclk);
        // index past the register list must be ignored
        cfg_index <= CFG_NONE;
        cfg_wdata <= $urandom;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_shadow.rescan_drops     = thr;
        cfg_shadow.backoff_floor_ms = floor_ms;
        cfg_shadow.backoff_cap_ms   = cap_ms;
        settings_loaded++;
    endtask

    function automatic int unsigned pick_idle_limit();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 11;
        endcase
    endfunction

    // mostly disconnects and ticks on an advancing clock, some raw noise
    task automatic send_random_request(input logic [31:0] step_max);
        logic [1:0]  kind;
        logic [7:0]  reason;
        logic [31:0] now;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) kind = REQ_CONNECT;
        else if (pick < 45) kind = REQ_DISCONNECT;
        else if (pick < 95) kind = REQ_TICK;
        else kind = REQ_UNUSED;
        if ($urandom_range(0, 1) == 0) reason = notable_reasons[$urandom_range(0, 5)];
        else reason = 8'($urandom_range(0, 255));
        sim_ms = sim_ms + $urandom_range(0, step_max);
        if ($urandom_range(0, 9) == 0) now = $urandom;
        else now = sim_ms;
        send_request(kind, reason, now, $urandom_range(0, 9) < 3);
    endtask

    task automatic run_random_phase(input int count, input logic [31:0] step_max);
        for (int i = 0; i < count; i++) begin
            // new idling profile every 50 requests, zero included
            if (i % 50 == 0) begin
                tx_gap_max   = pick_idle_limit();
                rx_stall_max = pick_idle_limit();
            end
            send_random_request(step_max);
        end
    endtask

    // hand-picked sequence under the reset register values
    task automatic test_directed_cases();
        tx_gap_max   = 11;
        rx_stall_max = 11;
        // nothing armed yet, a tick with the link down does nothing
        send_request(REQ_TICK, 8'd0, 32'd0, 1'b0);
        // plain disconnect arms the retry at now plus the floor
        send_request(REQ_DISCONNECT, 8'd0, 32'd100, 1'b1);
        send_request(REQ_TICK, 8'd0, 32'd3099, 1'b0);  // one ms early
        send_request(REQ_TICK, 8'd0, 32'd3100, 1'b1);  // due but link up
        send_request(REQ_TICK, 8'd0, 32'd3100, 1'b0);  // due, link down
        // stale hint reasons, the first one arms a new retry
        send_request(REQ_DISCONNECT, REASON_STALE_A, 32'd5000, 1'b0);
        send_request(REQ_DISCONNECT, REASON_STALE_B, 32'd5001, 1'b0);
        send_request(REQ_DISCONNECT, REASON_STALE_C, 32'd5002, 1'b0);
        // counted drops up to the threshold
        send_request(REQ_DISCONNECT, REASON_DROP_A, 32'd5003, 1'b0);
        send_request(REQ_DISCONNECT, REASON_DROP_B, 32'd5004, 1'b0);
        send_request(REQ_DISCONNECT, REASON_BOTH, 32'd5005, 1'b0);
        send_request(REQ_DISCONNECT, REASON_DROP_A, 32'd5006, 1'b0);
        send_request(REQ_DISCONNECT, REASON_DROP_B, 32'd5007, 1'b0);
        // pending rescan wins over a retry that is also due
        send_request(REQ_TICK, 8'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_request(REQ_CONNECT, 8'hFF, 32'd0, 1'b1);
        // deadline wraps past the top of the time range
        send_request(REQ_DISCONNECT, 8'hFF, 32'hFFFF_FFFF, 1'b0);
        send_request(REQ_TICK, 8'd0, 32'd2998, 1'b0);
        send_request(REQ_TICK, 8'd0, 32'd2999, 1'b0);
        // drop and retry until the doubling sticks at the cap
        for (int i = 0; i < 4; i++) begin
            send_request(REQ_DISCONNECT, 8'd1, 32'd0, 1'b0);
            send_request(REQ_TICK, 8'd0, 32'hFFFF_FFFF, 1'b0);
        end
    endtask

    // random traffic across register settings, extremes included
    task automatic test_register_settings();
        load_settings(RESCAN_DROPS_RST, BACKOFF_FLOOR_RST, BACKOFF_CAP_RST);
        run_random_phase(280, 32'd5000);
        // tiny floor, unbounded cap: doubling runs into the 32-bit limit
        load_settings(8'd1, 32'd1, 32'hFFFF_FFFF);
        run_random_phase(280, 32'd8);
        // huge floor, cap of one
        load_settings(8'd255, 32'hFFFF_FFFF, 32'd1);
        run_random_phase(280, 32'd1 << 20);
        // zero threshold flags a rescan on every counted drop
        load_settings(8'd0, 32'd100, 32'd100);
        run_random_phase(280, 32'd200);
        load_settings(8'd3, 32'd500, 32'd64000);
        run_random_phase(280, 32'd3000);
        load_settings(8'd200, 32'd7, 32'd900);
        run_random_phase(280, 32'd300);
    endtask

    // long run of counted drops with no tick pushes the counter to its ceiling
    task automatic test_drop_saturation();
        logic [7:0] counted [3];
        counted = '{REASON_DROP_A, REASON_DROP_B, REASON_BOTH};
        load_settings(8'd255, BACKOFF_FLOOR_RST, BACKOFF_CAP_RST);
        tx_gap_max   = 2;
        rx_stall_max = 2;
        send_request(REQ_CONNECT, 8'd0, sim_ms, 1'b1);
        for (int i = 0; i < 260; i++) begin
            send_request(REQ_DISCONNECT, counted[$urandom_range(0, 2)], $urandom, 1'b0);
        end
        send_request(REQ_TICK, 8'd0, $urandom, 1'b0);
    endtask

    // result side holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        wait_for_results();
        tx_gap_max     = 0;
        rx_stall_max   = 0;
        rx_hold_cycles = 150;
        for (int i = 0; i < 40; i++) send_random_request(32'd4000);
        wait_for_results();
    endtask

    initial begin
        cfg_shadow = '{RESCAN_DROPS_RST, BACKOFF_FLOOR_RST, BACKOFF_CAP_RST};
        sched             = '0;
        sched.backoff_now = BACKOFF_FLOOR_RST;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_register_settings();
        test_drop_saturation();
        test_backpressure();

        wait_for_results();
        // a few more cycles to catch any stray result
        repeat (10) @(posedge aclk);
        if (predicted_outcomes.size() != 0) begin
            $error("%0d results never arrived", predicted_outcomes.size());
            error_count++;
        end

        $display("run covered %0d requests under %0d register settings, %0d results checked",
                 requests_sent, settings_loaded, results_checked);
        $display("reconnects seen: %0d, rescans seen: %0d, errors: %0d",
                 reconnects_seen, rescans_seen, error_count);
        if (error_count == 0) begin
            $display("link_reconnect_backoff_controller: match");
        end else begin
            $display("link_reconnect_backoff_controller: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/lrbc_pkg.sv
rtl/lrbc_core.sv
rtl/link_reconnect_backoff_controller.sv
test/link_reconnect_backoff_controller_tb.sv
